// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the fuzzy gain scheduler.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge out of reset.
`define FPGS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define FPGS_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/fpgs_pkg.sv
// Shared types, constants and rule tables of the fuzzy PID gain scheduler.
// No dependencies; every other RTL file but assert_macros.svh refers to it by scoped names.
`default_nettype none

package fpgs_pkg;

	// Grid and fixed point constants
	localparam int GRID      = 7;
	localparam int NUM_GAINS = 3;
	localparam logic [12:0] WEIGHT_ONE = 13'd4096;   // 1.0 in Q1.12
	localparam logic signed [14:0] SPAN_POS = 15'sd12288;  // +3.0 in Q.12
	localparam logic signed [14:0] SPAN_NEG = -15'sd12288; // -3.0 in Q.12
	localparam logic [15:0] SPAN_OFFSET = 16'd12288;
	localparam logic [2:0] LAST_IDX = 3'd5;   // last interval start
	localparam logic [2:0] EDGE_IDX = 3'd6;   // position exactly at +3
	localparam logic signed [19:0] GAIN_MAX = 20'sd524287;
	localparam logic signed [19:0] GAIN_MIN = -20'sd524288;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ERROR_LIMIT   = 3'd0,
		REG_CHANGE_LIMIT  = 3'd1,
		REG_ERROR_QGAIN   = 3'd2,
		REG_CHANGE_QGAIN  = 3'd3,
		REG_PROP_SCALE    = 3'd4,
		REG_INTEG_SCALE   = 3'd5,
		REG_DERIV_SCALE   = 3'd6
	} cfg_reg_t;

	// Register reset values
	localparam logic [14:0] ERROR_LIMIT_RST  = 15'd2560;
	localparam logic [14:0] CHANGE_LIMIT_RST = 15'd2560;
	localparam logic [15:0] ERROR_QGAIN_RST  = 16'd4915;
	localparam logic [15:0] CHANGE_QGAIN_RST = 16'd4915;
	localparam logic [15:0] PROP_SCALE_RST   = 16'd8192;
	localparam logic [15:0] INTEG_SCALE_RST  = 16'd0;
	localparam logic [15:0] DERIV_SCALE_RST  = 16'd0;

	typedef logic [2:0]         grid_idx_t;
	typedef logic [12:0]        weight_t;
	typedef logic [24:0]        wprod_t;
	typedef logic signed [2:0]  rule_t;
	typedef logic signed [27:0] wsum_t;
	typedef logic [15:0]        scale_t;

	typedef struct packed {
		logic signed [15:0] error_in;
		logic signed [15:0] error_change;
	} sample_t;

	typedef struct packed {
		logic signed [19:0] prop_gain;
		logic signed [19:0] integ_gain;
		logic signed [19:0] deriv_gain;
	} gains_t;

	typedef struct packed {
		logic [14:0] error_limit;
		logic [14:0] change_limit;
		logic [15:0] error_quant_gain;
		logic [15:0] change_quant_gain;
		scale_t      prop_out_scale;
		scale_t      integ_out_scale;
		scale_t      deriv_out_scale;
	} cfg_t;

	// Interval start and right weight of one fuzzified input
	typedef struct packed {
		grid_idx_t idx;
		weight_t   wr;
	} fuzz_t;

	// Per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	// Rule bases: proportional, integral, derivative; row by error, column by change
	localparam rule_t RULES [NUM_GAINS][GRID][GRID] = '{
		'{
			'{3'sd3, 3'sd3, 3'sd2, 3'sd3, 3'sd1, 3'sd2, 3'sd0},
			'{3'sd3, 3'sd2, 3'sd2, 3'sd2, 3'sd1, 3'sd2, 3'sd0},
			'{3'sd2, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd2},
			'{3'sd2, 3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd2},
			'{3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd2, 3'sd2},
			'{3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd3, 3'sd3, 3'sd3},
			'{3'sd2, 3'sd3, 3'sd3, 3'sd3, 3'sd3, 3'sd3, 3'sd3}
		},
		'{
			'{-3'sd3, -3'sd3, -3'sd3, -3'sd3, -3'sd2, -3'sd3, -3'sd3},
			'{-3'sd3, -3'sd3, -3'sd2, -3'sd2, -3'sd2, -3'sd3, -3'sd3},
			'{-3'sd2, -3'sd2, -3'sd1, -3'sd1, -3'sd1, -3'sd2, -3'sd2},
			'{-3'sd2, -3'sd1,  3'sd0,  3'sd0,  3'sd0, -3'sd1, -3'sd2},
			'{-3'sd2, -3'sd1, -3'sd1, -3'sd1, -3'sd1, -3'sd2, -3'sd2},
			'{-3'sd2, -3'sd2, -3'sd1, -3'sd2, -3'sd2, -3'sd3, -3'sd3},
			'{-3'sd2, -3'sd3, -3'sd2, -3'sd3, -3'sd3, -3'sd3, -3'sd3}
		},
		'{
			'{ 3'sd1,  3'sd1,  3'sd0,  3'sd0, 3'sd0,  3'sd3, 3'sd3},
			'{-3'sd1, -3'sd1, -3'sd1, -3'sd1, 3'sd0, -3'sd1, 3'sd2},
			'{-3'sd3, -3'sd3, -3'sd2, -3'sd1, 3'sd0,  3'sd1, 3'sd2},
			'{-3'sd3, -3'sd2, -3'sd2, -3'sd1, 3'sd0,  3'sd1, 3'sd2},
			'{-3'sd3, -3'sd2, -3'sd1, -3'sd1, 3'sd0,  3'sd1, 3'sd1},
			'{-3'sd2, -3'sd1, -3'sd1, -3'sd1, 3'sd0,  3'sd1, 3'sd1},
			'{ 3'sd1,  3'sd0,  3'sd0,  3'sd0, 3'sd0,  3'sd3, 3'sd3}
		}
	};

endpackage

`default_nettype wire

// File: rtl/fpgs_cfg.sv
// Configuration register file of the fuzzy gain scheduler.
// Depends on fpgs_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module fpgs_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	output fpgs_pkg::cfg_t         cfg
);

	fpgs_pkg::cfg_t cfg_q;

	// Writes are always accepted
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Decode the index and update one register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_limit       <= fpgs_pkg::ERROR_LIMIT_RST;
			cfg_q.change_limit      <= fpgs_pkg::CHANGE_LIMIT_RST;
			cfg_q.error_quant_gain  <= fpgs_pkg::ERROR_QGAIN_RST;
			cfg_q.change_quant_gain <= fpgs_pkg::CHANGE_QGAIN_RST;
			cfg_q.prop_out_scale    <= fpgs_pkg::PROP_SCALE_RST;
			cfg_q.integ_out_scale   <= fpgs_pkg::INTEG_SCALE_RST;
			cfg_q.deriv_out_scale   <= fpgs_pkg::DERIV_SCALE_RST;
		end else if (cfg_valid) begin
			unique case (fpgs_pkg::cfg_reg_t'(cfg_index))
				fpgs_pkg::REG_ERROR_LIMIT:  cfg_q.error_limit       <= cfg_data[14:0];
				fpgs_pkg::REG_CHANGE_LIMIT: cfg_q.change_limit      <= cfg_data[14:0];
				fpgs_pkg::REG_ERROR_QGAIN:  cfg_q.error_quant_gain  <= cfg_data;
				fpgs_pkg::REG_CHANGE_QGAIN: cfg_q.change_quant_gain <= cfg_data;
				fpgs_pkg::REG_PROP_SCALE:   cfg_q.prop_out_scale    <= cfg_data;
				fpgs_pkg::REG_INTEG_SCALE:  cfg_q.integ_out_scale   <= cfg_data;
				fpgs_pkg::REG_DERIV_SCALE:  cfg_q.deriv_out_scale   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/fpgs_fuzzify.sv
// Stages 1 and 2: clamp and quantize one input, then split it into grid interval and weight.
// Depends on fpgs_pkg for fuzz_t, pipe_en_t and the universe constants.
`default_nettype none

module fpgs_fuzzify (
	input  wire logic               clk,
	input  wire fpgs_pkg::pipe_en_t pen,
	input  wire logic signed [15:0] value,
	input  wire logic [14:0]        limit,
	input  wire logic [15:0]        quant_gain,
	output fpgs_pkg::fuzz_t         fuzz
);

	logic signed [16:0] lim_pos;
	logic signed [16:0] lim_neg;
	logic signed [16:0] clamped;
	logic signed [33:0] prod;
	logic signed [31:0] prod_s1;

	logic signed [21:0] pos;
	logic signed [14:0] pos_sat;
	logic [15:0]        u;
	fpgs_pkg::fuzz_t    fuzz_next;
	fpgs_pkg::fuzz_t    fuzz_s2;

	// Clamp to +-limit and scale by the quantization gain
	always_comb begin
		lim_pos = $signed({2'b00, limit});
		lim_neg = -lim_pos;
		clamped = 17'(value);
		if (clamped > lim_pos) begin
			clamped = lim_pos;
		end else if (clamped < lim_neg) begin
			clamped = lim_neg;
		end
		prod = clamped * $signed({1'b0, quant_gain});
	end

	// The product magnitude stays below 2^31
	always_ff @(posedge clk) begin
		if (pen.s1) begin
			prod_s1 <= prod[31:0];
		end
	end

	// Floor shift to Q.12, saturate to +-3, locate the grid interval
	always_comb begin
		pos = prod_s1[31:10];
		if (pos > 22'(fpgs_pkg::SPAN_POS)) begin
			pos_sat = fpgs_pkg::SPAN_POS;
		end else if (pos < 22'(fpgs_pkg::SPAN_NEG)) begin
			pos_sat = fpgs_pkg::SPAN_NEG;
		end else begin
			pos_sat = pos[14:0];
		end
		u = 16'(pos_sat) + fpgs_pkg::SPAN_OFFSET;
		if (u[14:12] == fpgs_pkg::EDGE_IDX) begin
			fuzz_next.idx = fpgs_pkg::LAST_IDX;
			fuzz_next.wr  = fpgs_pkg::WEIGHT_ONE;
		end else begin
			fuzz_next.idx = u[14:12];
			fuzz_next.wr  = {1'b0, u[11:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (pen.s2) begin
			fuzz_s2 <= fuzz_next;
		end
	end

	assign fuzz = fuzz_s2;

endmodule

`default_nettype wire

// File: rtl/fpgs_rule.sv
// Stages 3 and 4: weight products and rule lookups, then the weighted rule sums.
// Depends on fpgs_pkg for the rule tables, fuzz_t and pipe_en_t.
`default_nettype none

module fpgs_rule (
	input  wire logic               clk,
	input  wire fpgs_pkg::pipe_en_t pen,
	input  wire fpgs_pkg::fuzz_t    fuzz_e,
	input  wire fpgs_pkg::fuzz_t    fuzz_c,
	output fpgs_pkg::wsum_t         wsum [fpgs_pkg::NUM_GAINS]
);

	// Corner order: left-left, left-right, right-left, right-right
	localparam int CORNERS = 4;

	fpgs_pkg::weight_t   wle;
	fpgs_pkg::weight_t   wlc;
	fpgs_pkg::grid_idx_t ie_n;
	fpgs_pkg::grid_idx_t ic_n;
	fpgs_pkg::wprod_t    wp_s3   [CORNERS];
	fpgs_pkg::rule_t     rule_s3 [fpgs_pkg::NUM_GAINS][CORNERS];
	fpgs_pkg::wsum_t     sum_next[fpgs_pkg::NUM_GAINS];
	fpgs_pkg::wsum_t     sum_s4  [fpgs_pkg::NUM_GAINS];

	always_comb begin
		wle  = fpgs_pkg::WEIGHT_ONE - fuzz_e.wr;
		wlc  = fpgs_pkg::WEIGHT_ONE - fuzz_c.wr;
		ie_n = fuzz_e.idx + 3'd1;
		ic_n = fuzz_c.idx + 3'd1;
	end

	// Form the four weight products and fetch the four corner rules of each table
	always_ff @(posedge clk) begin
		if (pen.s3) begin
			wp_s3[0] <= 25'(wle * wlc);
			wp_s3[1] <= 25'(wle * fuzz_c.wr);
			wp_s3[2] <= 25'(fuzz_e.wr * wlc);
			wp_s3[3] <= 25'(fuzz_e.wr * fuzz_c.wr);
			for (int t = 0; t < fpgs_pkg::NUM_GAINS; t++) begin
				rule_s3[t][0] <= fpgs_pkg::RULES[t][fuzz_e.idx][fuzz_c.idx];
				rule_s3[t][1] <= fpgs_pkg::RULES[t][fuzz_e.idx][ic_n];
				rule_s3[t][2] <= fpgs_pkg::RULES[t][ie_n][fuzz_c.idx];
				rule_s3[t][3] <= fpgs_pkg::RULES[t][ie_n][ic_n];
			end
		end
	end

	// Sum the rule-weighted corners of each table (Q.24)
	always_comb begin
		for (int t = 0; t < fpgs_pkg::NUM_GAINS; t++) begin
			sum_next[t] = '0;
			for (int q = 0; q < CORNERS; q++) begin
				sum_next[t] = sum_next[t]
					+ $signed({3'b000, wp_s3[q]}) * 28'(rule_s3[t][q]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pen.s4) begin
			sum_s4 <= sum_next;
		end
	end

	assign wsum = sum_s4;

endmodule

`default_nettype wire

// File: rtl/fpgs_defuzz.sv
// Stages 5 and 6 of one gain: multiply by the output scale, floor shift and saturate.
// Depends on fpgs_pkg for wsum_t, scale_t, pipe_en_t and the gain limits.
`default_nettype none

module fpgs_defuzz (
	input  wire logic               clk,
	input  wire fpgs_pkg::pipe_en_t pen,
	input  wire fpgs_pkg::wsum_t    wsum,
	input  wire fpgs_pkg::scale_t   scale,
	output logic signed [19:0]      gain
);

	logic signed [44:0] prod_s5;
	logic signed [20:0] shifted;
	logic signed [19:0] gain_next;
	logic signed [19:0] gain_s6;

	// Scale the rule sum: Q.24 times Q4.12 gives Q.36
	always_ff @(posedge clk) begin
		if (pen.s5) begin
			prod_s5 <= wsum * $signed({1'b0, scale});
		end
	end

	// Drop 24 fraction bits toward minus infinity and saturate to 20 bits
	always_comb begin
		shifted = prod_s5[44:24];
		if (shifted > 21'(fpgs_pkg::GAIN_MAX)) begin
			gain_next = fpgs_pkg::GAIN_MAX;
		end else if (shifted < 21'(fpgs_pkg::GAIN_MIN)) begin
			gain_next = fpgs_pkg::GAIN_MIN;
		end else begin
			gain_next = shifted[19:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pen.s6) begin
			gain_s6 <= gain_next;
		end
	end

	assign gain = gain_s6;

endmodule

`default_nettype wire

// File: rtl/fuzzy_pid_gain_scheduler_unit.sv
// Top level of the fuzzy PID gain scheduler: pipeline control and stage wiring.
// Depends on fpgs_pkg, assert_macros.svh, fpgs_cfg, fpgs_fuzzify, fpgs_rule, fpgs_defuzz.
//
// Takes one (error, error change) sample per transaction and returns one set of
// proportional, integral and derivative gains per sample, in order. The datapath is
// a six-stage pipeline: clamp and quantize, interval and weight, weight products and
// rule lookup, weighted sums, output scaling, shift and saturate into the output
// register. A sample enters every cycle while sample_stall is low; its gains travel
// through the stage registers s1 to s6 in order and sit in the output register, which
// holds them while gain_stall is high. Each stage owns its multipliers, so throughput is
// one sample per clock when the output side does not stall. Stall propagates back only
// through full stages, so bubbles are squeezed out. The configuration port takes a write
// every cycle; write registers only while no sample is in flight.
`default_nettype none
`include "assert_macros.svh"

module fuzzy_pid_gain_scheduler_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire fpgs_pkg::sample_t sample,
	output logic                   gain_valid,
	input  wire logic              gain_stall,
	output fpgs_pkg::gains_t       gains,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);

	fpgs_pkg::cfg_t     cfg;
	fpgs_pkg::pipe_en_t pen;
	fpgs_pkg::fuzz_t    fuzz_e;
	fpgs_pkg::fuzz_t    fuzz_c;
	fpgs_pkg::wsum_t    wsum [fpgs_pkg::NUM_GAINS];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	fpgs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A stage loads when it is empty or the stage after it loads
	always_comb begin
		pen.s6 = !v_s6 || !gain_stall;
		pen.s5 = !v_s5 || pen.s6;
		pen.s4 = !v_s4 || pen.s5;
		pen.s3 = !v_s3 || pen.s4;
		pen.s2 = !v_s2 || pen.s3;
		pen.s1 = !v_s1 || pen.s2;
	end

	assign sample_stall = !pen.s1;
	assign gain_valid   = v_s6;

	// Advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (pen.s1) v_s1 <= sample_valid;
			if (pen.s2) v_s2 <= v_s1;
			if (pen.s3) v_s3 <= v_s2;
			if (pen.s4) v_s4 <= v_s3;
			if (pen.s5) v_s5 <= v_s4;
			if (pen.s6) v_s6 <= v_s5;
		end
	end

	fpgs_fuzzify u_fuzz_error (
		.clk        (clk),
		.pen        (pen),
		.value      (sample.error_in),
		.limit      (cfg.error_limit),
		.quant_gain (cfg.error_quant_gain),
		.fuzz       (fuzz_e)
	);

	fpgs_fuzzify u_fuzz_change (
		.clk        (clk),
		.pen        (pen),
		.value      (sample.error_change),
		.limit      (cfg.change_limit),
		.quant_gain (cfg.change_quant_gain),
		.fuzz       (fuzz_c)
	);

	fpgs_rule u_rule (
		.clk    (clk),
		.pen    (pen),
		.fuzz_e (fuzz_e),
		.fuzz_c (fuzz_c),
		.wsum   (wsum)
	);

	fpgs_defuzz u_defuzz_prop (
		.clk   (clk),
		.pen   (pen),
		.wsum  (wsum[0]),
		.scale (cfg.prop_out_scale),
		.gain  (gains.prop_gain)
	);

	fpgs_defuzz u_defuzz_integ (
		.clk   (clk),
		.pen   (pen),
		.wsum  (wsum[1]),
		.scale (cfg.integ_out_scale),
		.gain  (gains.integ_gain)
	);

	fpgs_defuzz u_defuzz_deriv (
		.clk   (clk),
		.pen   (pen),
		.wsum  (wsum[2]),
		.scale (cfg.deriv_out_scale),
		.gain  (gains.deriv_gain)
	);

	// Pipeline control checks
	`FPGS_ASSERT_NEXT(a_accept_fills_s1, sample_valid && !sample_stall, v_s1, "accepted sample not in stage 1")
	`FPGS_ASSERT_NEXT(a_s5_reaches_out, v_s5 && pen.s6, gain_valid, "stage 5 item lost on its way out")
	`FPGS_ASSERT(a_stall_only_full, !sample_stall || (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && gain_stall), "input stalled with an empty stage")
	`FPGS_ASSERT_NEXT(a_held_s3_keeps, v_s3 && !pen.s3, v_s3, "held stage 3 item dropped")

endmodule

`default_nettype wire
